@@ hw/rtl/mlfr_pkg.sv @@
// Shared types and codes for the length-prefixed frame receiver.
package mlfr_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 16;
  localparam int unsigned IdxW  = 3;

  // parser phases
  localparam logic [1:0] PH_HUNT   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_KEEP   = 2'd2;
  localparam logic [1:0] PH_DROP   = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_DATA     = 2'd0;
  localparam logic [1:0] KIND_EMPTY    = 2'd1;
  localparam logic [1:0] KIND_OVERSIZE = 2'd2;
  localparam logic [1:0] KIND_TIMEOUT  = 2'd3;

  // request types
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // header byte positions after the start byte
  localparam logic [1:0] HDR_TYPE = 2'd0;
  localparam logic [1:0] HDR_LENH = 2'd1;
  localparam logic [1:0] HDR_LENL = 2'd2;

  // register indexes
  localparam logic [IdxW-1:0] REG_START_BYTE  = 3'd0;
  localparam logic [IdxW-1:0] REG_WANTED_TYPE = 3'd1;
  localparam logic [IdxW-1:0] REG_OTHER_TYPE  = 3'd2;
  localparam logic [IdxW-1:0] REG_MAX_LEN     = 3'd3;
  localparam logic [IdxW-1:0] REG_TIMEOUT     = 3'd4;

  localparam logic [LenW-1:0] TICKS_MAX = '1;

  typedef struct packed {
    logic [ByteW-1:0] start_byte;
    logic [ByteW-1:0] wanted_type_byte;
    logic [ByteW-1:0] other_type_byte;
    logic [LenW-1:0]  max_payload_len;
    logic [LenW-1:0]  timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [ByteW-1:0] payload_byte;
    logic             last;
  } result_t;

endpackage

@@ hw/rtl/mlfr_cfg.sv @@
// Configuration register file.
module mlfr_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mlfr_pkg::IdxW-1:0]    cfg_index,
  input  logic [mlfr_pkg::LenW-1:0]    cfg_data,
  output mlfr_pkg::cfg_t               cfg
);
  import mlfr_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte       <= 8'd148;
      cfg.wanted_type_byte <= 8'd196;
      cfg.other_type_byte  <= 8'd195;
      cfg.max_payload_len  <= 16'd512;
      cfg.timeout_ms       <= 16'd1000;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_START_BYTE:  cfg.start_byte       <= cfg_data[ByteW-1:0];
        REG_WANTED_TYPE: cfg.wanted_type_byte <= cfg_data[ByteW-1:0];
        REG_OTHER_TYPE:  cfg.other_type_byte  <= cfg_data[ByteW-1:0];
        REG_MAX_LEN:     cfg.max_payload_len  <= cfg_data;
        REG_TIMEOUT:     cfg.timeout_ms       <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/mlfr_parser.sv @@
// Frame parser state and per-request next-state and result logic.
module mlfr_parser (
  input  logic                       clk,
  input  logic                       rst,
  input  mlfr_pkg::cfg_t             cfg,
  input  logic                       req_fire,
  input  logic                       req_type,
  input  logic [mlfr_pkg::ByteW-1:0] rx_byte,
  output logic                       res_valid,
  output mlfr_pkg::result_t          res
);
  import mlfr_pkg::*;

  logic [1:0]       phase, phase_next;
  logic [1:0]       header_count, header_count_next;
  logic [ByteW-1:0] type_seen, type_seen_next;
  logic [ByteW-1:0] length_high, length_high_next;
  logic [LenW-1:0]  bytes_left, bytes_left_next;
  logic [LenW-1:0]  segment_ticks, segment_ticks_next;

  logic [LenW-1:0]  ticks_inc;
  logic [LenW-1:0]  len;
  logic             fin;

  assign ticks_inc = (segment_ticks == TICKS_MAX) ? segment_ticks : segment_ticks + 1'b1;
  assign len       = {length_high, rx_byte};
  assign fin       = (bytes_left <= 16'd1);

  always_comb begin
    phase_next         = phase;
    header_count_next  = header_count;
    type_seen_next     = type_seen;
    length_high_next   = length_high;
    bytes_left_next    = bytes_left;
    segment_ticks_next = segment_ticks;
    res_valid          = 1'b0;
    res                = '{kind: KIND_DATA, payload_byte: '0, last: 1'b0};

    if (req_type == REQ_TICK) begin
      if (phase != PH_HUNT) begin
        if (ticks_inc >= cfg.timeout_ms) begin
          phase_next         = PH_HUNT;
          header_count_next  = '0;
          bytes_left_next    = '0;
          segment_ticks_next = '0;
          res_valid          = 1'b1;
          res.kind           = KIND_TIMEOUT;
        end else begin
          segment_ticks_next = ticks_inc;
        end
      end
    end else begin
      case (phase)
        PH_HUNT: begin
          if (rx_byte == cfg.start_byte) begin
            phase_next         = PH_HEADER;
            header_count_next  = '0;
            segment_ticks_next = '0;
          end
        end
        PH_HEADER: begin
          if (header_count == HDR_TYPE) begin
            type_seen_next    = rx_byte;
            header_count_next = HDR_LENH;
          end else if (header_count == HDR_LENH) begin
            length_high_next  = rx_byte;
            header_count_next = HDR_LENL;
          end else begin
            header_count_next  = '0;
            phase_next         = PH_HUNT;
            segment_ticks_next = '0;
            if (type_seen == cfg.wanted_type_byte) begin
              if (len > cfg.max_payload_len) begin
                res_valid = 1'b1;
                res.kind  = KIND_OVERSIZE;
              end else if (len == '0) begin
                res_valid = 1'b1;
                res.kind  = KIND_EMPTY;
              end else begin
                bytes_left_next = len;
                phase_next      = PH_KEEP;
              end
            end else if (type_seen == cfg.other_type_byte && len != '0) begin
              bytes_left_next = len;
              phase_next      = PH_DROP;
            end
          end
        end
        PH_KEEP, PH_DROP: begin
          if (fin) begin
            bytes_left_next    = '0;
            phase_next         = PH_HUNT;
            segment_ticks_next = '0;
          end else begin
            bytes_left_next = bytes_left - 1'b1;
          end
          if (phase == PH_KEEP) begin
            res_valid        = 1'b1;
            res.kind         = KIND_DATA;
            res.payload_byte = rx_byte;
            res.last         = fin;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      header_count  <= '0;
      type_seen     <= '0;
      length_high   <= '0;
      bytes_left    <= '0;
      segment_ticks <= '0;
    end else if (req_fire) begin
      phase         <= phase_next;
      header_count  <= header_count_next;
      type_seen     <= type_seen_next;
      length_high   <= length_high_next;
      bytes_left    <= bytes_left_next;
      segment_ticks <= segment_ticks_next;
    end
  end

endmodule

@@ hw/rtl/mlfr_out_reg.sv @@
// Result register between the parser and the output stream.
module mlfr_out_reg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_fire,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  mlfr_pkg::result_t           in_res,
  output logic                        out_valid,
  input  logic                        out_ready,
  output mlfr_pkg::result_t           out_res
);
  import mlfr_pkg::*;

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_fire && in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_fire && in_valid) begin
      out_res <= in_res;
    end
  end

endmodule

@@ hw/rtl/magic_length_frame_receiver.sv @@
// Start-byte, length-prefixed frame receiver: top level.
// Output: registered; a result is valid in the cycle after its request is taken.
// Throughput: one request per cycle when not back-pressured.
// Back-pressure: a request is taken while the result register is empty or being drained.
// Reset: synchronous; registers return to their defaults, the parser returns to hunting.
module magic_length_frame_receiver (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [mlfr_pkg::ByteW-1:0]   s_axis_tdata,  // [7:0] rx_byte
  input  logic                         s_axis_tuser,  // [0] req_type
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [mlfr_pkg::ByteW-1:0]   m_axis_tdata,  // [7:0] payload_byte
  output logic [1:0]                   m_axis_tuser,  // [1:0] kind
  output logic                         m_axis_tlast,  // last
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mlfr_pkg::IdxW-1:0]    cfg_index,
  input  logic [mlfr_pkg::LenW-1:0]    cfg_data
);
  import mlfr_pkg::*;

  cfg_t    cfg;
  result_t res;
  result_t out_res;
  logic    res_valid;
  logic    req_fire;

  assign req_fire = s_axis_tvalid && s_axis_tready;

  mlfr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mlfr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_fire  (req_fire),
    .req_type  (s_axis_tuser),
    .rx_byte   (s_axis_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  mlfr_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (req_fire),
    .in_valid  (res_valid),
    .in_ready  (s_axis_tready),
    .in_res    (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  assign m_axis_tdata = out_res.payload_byte;
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the start-byte, length-prefixed frame receiver.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mlfr_pkg::*;

  localparam logic [ByteW-1:0] DEF_START  = 8'd148;
  localparam logic [ByteW-1:0] DEF_WANTED = 8'd196;
  localparam logic [ByteW-1:0] DEF_OTHER  = 8'd195;
  localparam logic [LenW-1:0]  DEF_MAXLEN = 16'd512;
  localparam logic [LenW-1:0]  DEF_TMO    = 16'd1000;
  localparam int               DueDepth   = 16;

  class frame_scoreboard;
    logic [ByteW-1:0] start_b, wanted_t, other_t;
    logic [LenW-1:0]  max_len, tmo_ticks;
    logic [1:0]       prs_phase, hdr_cnt;
    logic [ByteW-1:0] type_seen, len_hi;
    logic [LenW-1:0]  bytes_left, seg_ticks;
    result_t          due_buf[DueDepth];
    logic [3:0]       due_head, due_tail;
    int               due_count;
    int errors, n_data, n_last, n_empty, n_oversize, n_timeout;

    function new();
      start_b    = DEF_START;
      wanted_t   = DEF_WANTED;
      other_t    = DEF_OTHER;
      max_len    = DEF_MAXLEN;
      tmo_ticks  = DEF_TMO;
      prs_phase  = PH_HUNT;
      hdr_cnt    = HDR_TYPE;
      type_seen  = '0;
      len_hi     = '0;
      bytes_left = '0;
      seg_ticks  = '0;
      due_head   = '0;
      due_tail   = '0;
      due_count  = 0;
    endfunction

    function void set_reg(logic [IdxW-1:0] idx, logic [LenW-1:0] val);
      case (idx)
        REG_START_BYTE:  start_b   = val[ByteW-1:0];
        REG_WANTED_TYPE: wanted_t  = val[ByteW-1:0];
        REG_OTHER_TYPE:  other_t   = val[ByteW-1:0];
        REG_MAX_LEN:     max_len   = val;
        REG_TIMEOUT:     tmo_ticks = val;
        default: ;
      endcase
    endfunction

    function void push(logic [1:0] kind, logic [ByteW-1:0] b, logic fin);
      result_t r;
      r.kind = kind;
      r.payload_byte = b;
      r.last = fin;
      if (due_count == DueDepth) begin
        errors++;
        $display("%0t: too many results outstanding", $realtime);
        return;
      end
      due_buf[due_tail] = r;
      due_tail++;
      due_count++;
    endfunction

    // advance the frame parser by one accepted request
    function void take_request(logic req, logic [ByteW-1:0] b);
      logic [LenW-1:0] len;
      logic fin;
      if (req == REQ_TICK) begin
        if (prs_phase == PH_HUNT) return;
        if (seg_ticks != TICKS_MAX) seg_ticks++;
        if (seg_ticks >= tmo_ticks) begin
          prs_phase  = PH_HUNT;
          hdr_cnt    = HDR_TYPE;
          bytes_left = '0;
          seg_ticks  = '0;
          push(KIND_TIMEOUT, '0, 1'b0);
        end
        return;
      end
      case (prs_phase)
        PH_HUNT: begin
          if (b == start_b) begin
            prs_phase = PH_HEADER;
            hdr_cnt   = HDR_TYPE;
            seg_ticks = '0;
          end
        end
        PH_HEADER: begin
          if (hdr_cnt == HDR_TYPE) begin
            type_seen = b;
            hdr_cnt   = HDR_LENH;
          end else if (hdr_cnt == HDR_LENH) begin
            len_hi  = b;
            hdr_cnt = HDR_LENL;
          end else begin
            len       = {len_hi, b};
            hdr_cnt   = HDR_TYPE;
            prs_phase = PH_HUNT;
            seg_ticks = '0;
            if (type_seen == wanted_t) begin
              if (len > max_len) push(KIND_OVERSIZE, '0, 1'b0);
              else if (len == '0) push(KIND_EMPTY, '0, 1'b0);
              else begin
                bytes_left = len;
                prs_phase  = PH_KEEP;
              end
            end else if (type_seen == other_t && len != '0) begin
              bytes_left = len;
              prs_phase  = PH_DROP;
            end
          end
        end
        default: begin
          fin = (bytes_left <= 16'd1);
          if (prs_phase == PH_KEEP) push(KIND_DATA, b, fin);
          if (fin) begin
            bytes_left = '0;
            prs_phase  = PH_HUNT;
            seg_ticks  = '0;
          end else begin
            bytes_left--;
          end
        end
      endcase
    endfunction

    function void check_result(logic [1:0] kind, logic [ByteW-1:0] b, logic fin);
      result_t e;
      case (kind)
        KIND_DATA: begin
          n_data++;
          if (fin) n_last++;
        end
        KIND_EMPTY:    n_empty++;
        KIND_OVERSIZE: n_oversize++;
        default:       n_timeout++;
      endcase
      if (due_count == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result kind %0d byte %02h last %0b",
                   $realtime, kind, b, fin);
        return;
      end
      e = due_buf[due_head];
      due_head++;
      due_count--;
      if (e.kind !== kind || e.payload_byte !== b || e.last !== fin) begin
        errors++;
        if (errors <= 10)
          $display("%0t: kind/byte/last expected %0d/%02h/%0b, got %0d/%02h/%0b",
                   $realtime, e.kind, e.payload_byte, e.last, kind, b, fin);
      end
    endfunction

    function int pending();
      return due_count;
    endfunction

    function void close_out();
      if (due_count != 0) begin
        errors++;
        $display("%0t: %0d expected results never arrived", $realtime, due_count);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [ByteW-1:0]    s_axis_tdata = '0;
  logic                s_axis_tuser = REQ_BYTE;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [ByteW-1:0]    m_axis_tdata;
  logic [1:0]          m_axis_tuser;
  logic                m_axis_tlast;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [IdxW-1:0]     cfg_index = '0;
  logic [LenW-1:0]     cfg_data = '0;

  frame_scoreboard sb;
  bit src_gaps = 1'b1;
  bit sink_stalls = 1'b1;
  int n_sent = 0;
  int n_settings = 1;

  magic_length_frame_receiver uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
      if (s_axis_tvalid && s_axis_tready) sb.take_request(s_axis_tuser, s_axis_tdata);
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
    end
  end

  // mostly short idles, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    @(posedge clk);
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      if (sink_stalls) begin
        m_axis_tready <= 1'b0;
        repeat (1 + idle_len()) @(posedge clk);
      end
    end
  end

  task automatic send_req(input logic req, input logic [ByteW-1:0] b);
    int gap;
    gap = src_gaps ? idle_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    n_sent++;
  endtask

  task automatic send_byte(input logic [ByteW-1:0] b);
    send_req(REQ_BYTE, b);
  endtask

  task automatic send_tick();
    send_req(REQ_TICK, ByteW'($urandom));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [LenW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic [ByteW-1:0] st, input logic [ByteW-1:0] wt,
                           input logic [ByteW-1:0] ot, input logic [LenW-1:0] ml,
                           input logic [LenW-1:0] tm);
    wait_idle();
    write_reg(REG_START_BYTE, {8'd0, st});
    write_reg(REG_WANTED_TYPE, {8'd0, wt});
    write_reg(REG_OTHER_TYPE, {8'd0, ot});
    write_reg(REG_MAX_LEN, ml);
    write_reg(REG_TIMEOUT, tm);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [LenW-1:0] pick_len(bit wanted_f);
    int r, cap;
    r = $urandom_range(0, 99);
    cap = wanted_f ? int'(sb.max_len) : 65535;
    if (r < 8 || cap == 0) return '0;
    if (wanted_f && sb.max_len != 16'hFFFF && r < 22)
      return LenW'($urandom_range(int'(sb.max_len) + 1, 65535));
    if (r < 26) return LenW'($urandom_range(1, (cap < 300) ? cap : 300));
    return LenW'($urandom_range(1, (cap < 16) ? cap : 16));
  endfunction

  task automatic maybe_tick(input int pct);
    if ($urandom_range(1, 100) <= pct) send_tick();
  endtask

  // one frame with random content; some carry ticks, some are cut short
  task automatic send_frame();
    logic [ByteW-1:0] t, b;
    logic [LenW-1:0]  len;
    int r, count, pct;
    bit wanted_f;
    r = $urandom_range(0, 99);
    if (r < 55) t = sb.wanted_t;
    else if (r < 85) t = sb.other_t;
    else t = ByteW'($urandom);
    wanted_f = (t == sb.wanted_t);
    len = pick_len(wanted_f);
    pct = ($urandom_range(0, 9) < 3) ? 8 : 0;
    repeat ($urandom_range(0, 2)) begin
      b = ByteW'($urandom);
      if (b == sb.start_b) b = ~b;
      send_byte(b);
    end
    send_byte(sb.start_b);
    maybe_tick(pct);
    send_byte(t);
    maybe_tick(pct);
    send_byte(len[15:8]);
    maybe_tick(pct);
    send_byte(len[7:0]);
    if (wanted_f) count = (len > sb.max_len) ? 0 : int'(len);
    else count = (t == sb.other_t) ? int'(len) : 0;
    if (count > 0 && $urandom_range(0, 9) == 0) count = $urandom_range(0, count - 1);
    for (int i = 0; i < count; i++) begin
      maybe_tick(pct);
      send_byte(ByteW'($urandom));
    end
  endtask

  task automatic random_part(input int n);
    int target;
    target = n_sent + n;
    while (n_sent < target) begin
      if ($urandom_range(0, 99) < 85) begin
        send_frame();
      end else begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 1)) send_tick();
          else send_byte(ByteW'($urandom));
        end
      end
      if ($urandom_range(0, 49) == 0) wait_idle();
    end
  endtask

  initial begin
    logic [ByteW-1:0] w;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_reg(REG_TIMEOUT, 16'd2);
    cfg_valid <= 1'b0;

    // hunting ignores ticks and stray bytes
    send_tick();
    send_byte(8'hFF);
    // wanted frame, start byte inside the payload taken as data
    send_byte(DEF_START); send_byte(DEF_WANTED); send_byte(8'h00); send_byte(8'h02);
    send_byte(8'hFF); send_byte(DEF_START);
    // empty wanted frame
    send_byte(DEF_START); send_byte(DEF_WANTED); send_byte(8'h00); send_byte(8'h00);
    // oversize: 513 against a limit of 512
    send_byte(DEF_START); send_byte(DEF_WANTED); send_byte(8'h02); send_byte(8'h01);
    // dropped frame, then an empty dropped frame
    send_byte(DEF_START); send_byte(DEF_OTHER); send_byte(8'h00); send_byte(8'h01);
    send_byte(8'h00);
    send_byte(DEF_START); send_byte(DEF_OTHER); send_byte(8'h00); send_byte(8'h00);
    // unknown type
    send_byte(DEF_START); send_byte(8'h5A); send_byte(8'h00); send_byte(8'h02);
    // header timeout
    send_byte(DEF_START); send_byte(DEF_WANTED); send_tick(); send_tick();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: configure(8'h00, 8'hFF, 8'h00, 16'h0000, 16'd1);
        1: configure(8'hFF, 8'h00, 8'hFF, 16'hFFFF, 16'hFFFF);
        2: begin
          w = ByteW'($urandom);
          configure(ByteW'($urandom), w, w, LenW'($urandom_range(1, 40)),
                    LenW'($urandom_range(3, 20)));
        end
        7: configure(DEF_START, DEF_WANTED, DEF_OTHER, DEF_MAXLEN, DEF_TMO);
        default: configure(ByteW'($urandom), ByteW'($urandom), ByteW'($urandom),
                           LenW'($urandom_range(1, 600)), LenW'($urandom_range(2, 30)));
      endcase
      src_gaps    = (p != 3);
      sink_stalls = (p != 3);
      random_part(180);
    end

    wait_idle();
    repeat (10) @(posedge clk);
    sb.close_out();
    $display("summary: %0d requests under %0d register settings, plus directed header cases",
             n_sent, n_settings);
    $display("summary: %0d payload bytes in %0d frames, %0d empty, %0d oversize, %0d timeouts",
             sb.n_data, sb.n_last, sb.n_empty, sb.n_oversize, sb.n_timeout);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("tb: failure");
    $finish;
  end
endmodule

@@ files.f @@
hw/rtl/mlfr_pkg.sv
hw/rtl/mlfr_cfg.sv
hw/rtl/mlfr_parser.sv
hw/rtl/mlfr_out_reg.sv
hw/rtl/magic_length_frame_receiver.sv
dv/testbench.sv
